// File: rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

  // Default physical address width of the walked tables.
  localparam int PA_BITS_DFLT = 44;

  // Fixed field widths.
  localparam int VA_W       = 48;
  localparam int ROOT_W     = 44;
  localparam int ENTRY_W    = 64;
  localparam int OUT_ADDR_W = 44;
  localparam int OFS_W      = 12;
  localparam int IDX_W      = 9;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;

  // Last level of the walk.
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  // Input command codes.
  typedef enum logic {
    CMD_START    = 1'b0,
    CMD_RESPONSE = 1'b1
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_STRAY   = 2'd2
  } kind_t;

  // Classified operation carried from front to back. The frame base travels
  // beside it, since its width follows the PA_BITS parameter.
  typedef struct packed {
    kind_t             kind;
    logic [1:0]        level;
    logic [OFS_W-1:0]  offset;
  } walk_op_t;

endpackage

`default_nettype wire

// File: rtl/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accepts input items, tracks the walk state and classifies each item into
// a base and an offset for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_front #(
  parameter int PA_BITS = ptw_pkg::PA_BITS_DFLT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic                        q_full,
  input  wire logic                        in_command,
  input  wire logic [ptw_pkg::VA_W-1:0]    in_virtual_address,
  input  wire logic [ptw_pkg::ROOT_W-1:0]  in_table_root,
  input  wire logic [ptw_pkg::ENTRY_W-1:0] in_entry_data,
  output      logic                        q_push,
  output      logic [PA_BITS-1:0]          q_base,
  output      ptw_pkg::walk_op_t           q_op,
  output      logic                        busy
);

  logic                       walk_busy_r, walk_busy_nxt;
  logic [1:0]                 level_r, level_nxt;
  logic [ptw_pkg::VA_W-1:0]   vaddr_r, vaddr_nxt;
  logic [PA_BITS-1:0]         root_pa;
  logic [PA_BITS-1:0]         frame;
  logic [1:0]                 next_level;
  logic [ptw_pkg::VA_W-1:0]   idx_va;
  logic [1:0]                 idx_level;
  logic [ptw_pkg::IDX_W-1:0]  idx;

  assign q_push = in_push && !q_full;
  assign busy   = walk_busy_r;

  generate
    if (PA_BITS > ptw_pkg::ROOT_W) begin : g_root_wide
      assign root_pa = {{(PA_BITS - ptw_pkg::ROOT_W){1'b0}}, in_table_root};
    end else begin : g_root_narrow
      assign root_pa = in_table_root[PA_BITS-1:0];
    end
  endgenerate

  assign frame      = {in_entry_data[PA_BITS-1:ptw_pkg::OFS_W], {ptw_pkg::OFS_W{1'b0}}};
  assign next_level = level_r + 2'd1;

  // Table index for the level being requested.
  assign idx_va    = (in_command == ptw_pkg::CMD_START) ? in_virtual_address : vaddr_r;
  assign idx_level = (in_command == ptw_pkg::CMD_START) ? 2'd0 : next_level;

  always_comb begin
    case (idx_level)
      2'd0:    idx = idx_va[47:39];
      2'd1:    idx = idx_va[38:30];
      2'd2:    idx = idx_va[29:21];
      default: idx = idx_va[20:12];
    endcase
  end

  always_comb begin
    walk_busy_nxt = walk_busy_r;
    level_nxt     = level_r;
    vaddr_nxt     = vaddr_r;
    q_base        = '0;
    q_op.kind     = ptw_pkg::KIND_STRAY;
    q_op.level    = 2'd0;
    q_op.offset   = '0;
    if (in_command == ptw_pkg::CMD_START) begin
      walk_busy_nxt = 1'b1;
      level_nxt     = 2'd0;
      vaddr_nxt     = in_virtual_address;
      q_base        = root_pa;
      q_op.kind     = ptw_pkg::KIND_REQUEST;
      q_op.offset   = {idx, 3'b000};
    end else if (walk_busy_r) begin
      q_base = frame;
      if (level_r == ptw_pkg::LEVEL_LAST) begin
        walk_busy_nxt = 1'b0;
        level_nxt     = 2'd0;
        q_op.kind     = ptw_pkg::KIND_DONE;
        q_op.level    = ptw_pkg::LEVEL_LAST;
        q_op.offset   = vaddr_r[ptw_pkg::OFS_W-1:0];
      end else begin
        level_nxt   = next_level;
        q_op.kind   = ptw_pkg::KIND_REQUEST;
        q_op.level  = next_level;
        q_op.offset = {idx, 3'b000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_busy_r <= 1'b0;
      level_r     <= 2'd0;
      vaddr_r     <= '0;
    end else if (q_push) begin
      walk_busy_r <= walk_busy_nxt;
      level_r     <= level_nxt;
      vaddr_r     <= vaddr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Small first-in first-out queue of classified operations between the
// front and the back of the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_queue #(
  parameter int PA_BITS = ptw_pkg::PA_BITS_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [PA_BITS-1:0] push_base,
  input  wire ptw_pkg::walk_op_t  push_op,
  output      logic               full,
  input  wire logic               pop,
  output      logic               empty,
  output      logic [PA_BITS-1:0] head_base,
  output      ptw_pkg::walk_op_t  head_op
);

  localparam int PTR_W = $clog2(ptw_pkg::QDEPTH);
  localparam int CNT_W = $clog2(ptw_pkg::QDEPTH + 1);

  logic [PA_BITS-1:0] base_r [ptw_pkg::QDEPTH];
  ptw_pkg::walk_op_t  op_r   [ptw_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(ptw_pkg::QDEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_base = base_r[rd_ptr_r];
  assign head_op   = op_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      base_r[wr_ptr_r] <= push_base;
      op_r[wr_ptr_r]   <= push_op;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Takes classified operations from the queue, forms the address and holds
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_back #(
  parameter int PA_BITS = ptw_pkg::PA_BITS_DFLT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire logic [PA_BITS-1:0]             q_base,
  input  wire ptw_pkg::walk_op_t              q_op,
  output      logic                           q_pop,
  output      logic                           out_empty,
  input  wire logic                           out_pop,
  output      logic [1:0]                     out_result_kind,
  output      logic [ptw_pkg::OUT_ADDR_W-1:0] out_result_address,
  output      logic [1:0]                     out_walk_level
);

  logic                            valid_r;
  logic [1:0]                      kind_r;
  logic [ptw_pkg::OUT_ADDR_W-1:0]  addr_r;
  logic [1:0]                      level_r;
  logic [PA_BITS-1:0]              sum;
  logic [ptw_pkg::OUT_ADDR_W-1:0]  addr_nxt;
  logic                            slot_free;

  // The sum wraps within PA_BITS bits.
  assign sum = q_base + {{(PA_BITS - ptw_pkg::OFS_W){1'b0}}, q_op.offset};

  generate
    if (PA_BITS >= ptw_pkg::OUT_ADDR_W) begin : g_out_narrow
      assign addr_nxt = sum[ptw_pkg::OUT_ADDR_W-1:0];
    end else begin : g_out_wide
      assign addr_nxt = {{(ptw_pkg::OUT_ADDR_W - PA_BITS){1'b0}}, sum};
    end
  endgenerate

  assign slot_free = !valid_r || out_pop;
  assign q_pop     = !q_empty && slot_free;
  assign out_empty = !valid_r;

  assign out_result_kind    = kind_r;
  assign out_result_address = addr_r;
  assign out_walk_level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r  <= q_op.kind;
      addr_r  <= addr_nxt;
      level_r <= q_op.level;
    end
  end

endmodule

`default_nettype wire

// File: rtl/four_level_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// Four-level page table walker for 48-bit virtual addresses.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake         Fields
//   -------  ----------------  ------------------------------------------------
//   in       in_push/in_full   command, virtual_address, table_root, entry_data
//   out      out_pop/out_empty result_kind, result_address, walk_level
//
// Every input transfer produces exactly one result transfer. A result is
// registered in the queue and then in the output register before it appears
// on the out ports. One item is taken per cycle while in_full is low: the
// walk state update in the front is the only loop, one compare and
// increment per item. The front-to-back queue holds four items. Reset is
// synchronous and clears the walk state, the queue pointers and the output
// valid flag. A stalled out side fills the queue and then raises in_full.
//
// The front keeps the walk state (busy flag, current level, saved virtual
// address). A start transfer latches the address and requests the top-level
// entry at the root plus the level-zero index times eight. A response while
// a walk is in progress masks the entry to its frame bits and either
// requests the next level or, after the fourth entry, reports the frame plus
// the page offset as the physical address. A response with no walk in
// progress is reported as a stray result with a zero address. A start while
// a walk is in progress abandons that walk.
//
// The back end does the final address add within PA_BITS bits and keeps the
// result in an output register, so the front keeps taking transfers while a
// result waits to be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_unit #(
  parameter int PA_BITS = ptw_pkg::PA_BITS_DFLT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output      logic                           in_full,
  input  wire logic                           in_command,
  input  wire logic [ptw_pkg::VA_W-1:0]       in_virtual_address,
  input  wire logic [ptw_pkg::ROOT_W-1:0]     in_table_root,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]    in_entry_data,
  output      logic                           out_empty,
  input  wire logic                           out_pop,
  output      logic [1:0]                     out_result_kind,
  output      logic [ptw_pkg::OUT_ADDR_W-1:0] out_result_address,
  output      logic [1:0]                     out_walk_level
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [PA_BITS-1:0] push_base;
  ptw_pkg::walk_op_t  push_op;
  logic [PA_BITS-1:0] head_base;
  ptw_pkg::walk_op_t  head_op;
  logic               walk_busy;

  assign in_full = q_full;

  ptw_front #(
    .PA_BITS (PA_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .q_full             (q_full),
    .in_command         (in_command),
    .in_virtual_address (in_virtual_address),
    .in_table_root      (in_table_root),
    .in_entry_data      (in_entry_data),
    .q_push             (q_push),
    .q_base             (push_base),
    .q_op               (push_op),
    .busy               (walk_busy)
  );

  ptw_queue #(
    .PA_BITS (PA_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_base (push_base),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_base (head_base),
    .head_op   (head_op)
  );

  ptw_back #(
    .PA_BITS (PA_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_base             (head_base),
    .q_op               (head_op),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_result_address (out_result_address),
    .out_walk_level     (out_walk_level)
  );

`ifndef NO_ASSERTIONS
  // The queue can never be full and empty at once.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // A start transfer always leaves a walk in progress.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_command == ptw_pkg::CMD_START) |=> walk_busy)
    else $error("walk not busy after a start transfer");

  // A finished translation is always reported at the last level.
  a_done_level: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == ptw_pkg::KIND_DONE)
      |-> (out_walk_level == ptw_pkg::LEVEL_LAST))
    else $error("done result not at last level");

  // A stray response carries a zero address and level.
  a_stray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind == ptw_pkg::KIND_STRAY)
      |-> (out_result_address == '0 && out_walk_level == 2'd0))
    else $error("stray result with nonzero address or level");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the four-level page table walker. A directed
// table covers the address and entry extremes, stray responses, a restarted
// walk and an unaligned root. Random walks then run under several sender and
// receiver idling mixes. Every result transfer is checked against the result
// typed into its directed row or against a local model of the walk state.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  // Cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Length of the receiver hold-off that fills the internal queue.
  localparam int unsigned HOLD_CYCLES = 60;
  // Cycles to wait after the last result.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned N_DIRECTED = 21;

  // One input transfer. When pinned is set, the expected result is the one
  // typed into the row instead of the one the walk model computes.
  typedef struct packed {
    cmd_t                  cmd;
    logic [VA_W-1:0]       va;
    logic [ROOT_W-1:0]     root;
    logic [ENTRY_W-1:0]    entry;
    logic                  pinned;
    kind_t                 kind;
    logic [OUT_ADDR_W-1:0] addr;
    logic [1:0]            lvl;
  } walk_stim_t;

  // One result transfer.
  typedef struct packed {
    kind_t                 kind;
    logic [OUT_ADDR_W-1:0] addr;
    logic [1:0]            lvl;
  } walk_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Block inputs start at known values.
  logic                  in_push = 1'b0;
  logic                  in_command = 1'b0;
  logic [VA_W-1:0]       in_virtual_address = '0;
  logic [ROOT_W-1:0]     in_table_root = '0;
  logic [ENTRY_W-1:0]    in_entry_data = '0;
  logic                  out_pop = 1'b0;
  logic                  in_full;
  logic                  out_empty;
  logic [1:0]            out_result_kind;
  logic [OUT_ADDR_W-1:0] out_result_address;
  logic [1:0]            out_walk_level;

  four_level_page_table_walker_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_command         (in_command),
    .in_virtual_address (in_virtual_address),
    .in_table_root      (in_table_root),
    .in_entry_data      (in_entry_data),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_result_address (out_result_address),
    .out_walk_level     (out_walk_level)
  );

  // Walk state of the local model, mirroring the block after reset.
  logic            model_busy = 1'b0;
  logic [1:0]      model_level = 2'd0;
  logic [VA_W-1:0] model_va = '0;

  // Results that have been predicted but not yet seen on the out side.
  walk_result_t pending_results[$];

  // Idling mix of the current phase, in percent of cycles.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active = 1'b0;
  event        start_hold;

  // Run statistics.
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned walks_done = 0;
  int unsigned strays_seen = 0;
  int unsigned full_stalls = 0;
  int unsigned mismatches = 0;

  // Directed rows. The first twelve have results that can be read off by
  // hand: a stray response straight after reset, a walk through all-zero
  // entries, a stray response after that walk completes, and a walk with
  // every address and entry bit set, where the root plus the top index wraps
  // around the 44-bit physical space. The remaining rows use an unaligned
  // root, entries with bits outside the frame field, and a new start while a
  // walk is still in progress; those are checked against the model.
  walk_stim_t directed_rows [N_DIRECTED] = '{
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hffff_ffff_ffff_ffff,
      1'b1, KIND_STRAY, 44'h0, 2'd0},
    '{CMD_START, 48'h0, 44'h0, 64'h0, 1'b1, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0, 1'b1, KIND_REQUEST, 44'h0, 2'd1},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0, 1'b1, KIND_REQUEST, 44'h0, 2'd2},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0, 1'b1, KIND_REQUEST, 44'h0, 2'd3},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0, 1'b1, KIND_DONE, 44'h0, 2'd3},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0, 1'b1, KIND_STRAY, 44'h0, 2'd0},
    '{CMD_START, 48'hffff_ffff_ffff, 44'hfff_ffff_ffff, 64'h0,
      1'b1, KIND_REQUEST, 44'h000_0000_0ff7, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hffff_ffff_ffff_ffff,
      1'b1, KIND_REQUEST, 44'hfff_ffff_fff8, 2'd1},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hffff_ffff_ffff_ffff,
      1'b1, KIND_REQUEST, 44'hfff_ffff_fff8, 2'd2},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hffff_ffff_ffff_ffff,
      1'b1, KIND_REQUEST, 44'hfff_ffff_fff8, 2'd3},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hffff_ffff_ffff_ffff,
      1'b1, KIND_DONE, 44'hfff_ffff_ffff, 2'd3},
    '{CMD_START, 48'h1234_5678_9abc, 44'h000_0000_0123, 64'h0,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'hfff0_0abc_def0_1fff,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_START, 48'h8040_2010_0abc, 44'h800_0000_0000, 64'h0,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0000_0555_5555_5000,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h8000_0aaa_aaaa_a063,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0000_0fff_ffff_f001,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h7ff0_0123_4567_8fff,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_START, 48'hffff_ffff_ffff, 44'hfff_ffff_f000, 64'h0,
      1'b0, KIND_REQUEST, 44'h0, 2'd0},
    '{CMD_RESPONSE, 48'h0, 44'h0, 64'h0,
      1'b0, KIND_REQUEST, 44'h0, 2'd0}
  };

  // Nine-bit table index of the virtual address for a given level.
  function automatic logic [IDX_W-1:0] table_index(logic [VA_W-1:0] va,
                                                  logic [1:0] lvl);
    case (lvl)
      2'd0: table_index = va[47:39];
      2'd1: table_index = va[38:30];
      2'd2: table_index = va[29:21];
      default: table_index = va[20:12];
    endcase
  endfunction

  // Advances the model's walk state by one accepted transfer and returns the
  // result that transfer should produce. All sums wrap within 44 bits.
  function automatic walk_result_t predict_walk(walk_stim_t item);
    logic [OUT_ADDR_W-1:0] frame;
    walk_result_t          res;
    if (item.cmd == CMD_START) begin
      model_va    = item.va;
      model_busy  = 1'b1;
      model_level = 2'd0;
      res = '{KIND_REQUEST,
              item.root + {32'b0, table_index(item.va, 2'd0), 3'b000}, 2'd0};
    end else if (!model_busy) begin
      res = '{KIND_STRAY, 44'h0, 2'd0};
    end else begin
      frame = {item.entry[OUT_ADDR_W-1:OFS_W], 12'h000};
      if (model_level == LEVEL_LAST) begin
        model_busy  = 1'b0;
        model_level = 2'd0;
        res = '{KIND_DONE, frame + {32'b0, model_va[OFS_W-1:0]}, LEVEL_LAST};
      end else begin
        model_level = model_level + 2'd1;
        res = '{KIND_REQUEST,
                frame + {32'b0, table_index(model_va, model_level), 3'b000},
                model_level};
      end
    end
    return res;
  endfunction

  // Random input item. Roots are mostly page aligned, with some unaligned
  // ones, and every field now and then takes its all-zero or all-one value.
  function automatic walk_stim_t random_item(cmd_t cmd);
    walk_stim_t item;
    logic [63:0] raw_va;
    logic [63:0] raw_root;
    raw_va   = {$urandom, $urandom};
    raw_root = {$urandom, $urandom};
    item        = '0;
    item.cmd    = cmd;
    item.pinned = 1'b0;
    item.kind   = KIND_REQUEST;
    case ($urandom_range(7))
      0: item.va = '1;
      1: item.va = '0;
      default: item.va = raw_va[VA_W-1:0];
    endcase
    case ($urandom_range(7))
      0: item.root = '1;
      1: item.root = '0;
      2, 3: item.root = raw_root[ROOT_W-1:0];
      default: item.root = {raw_root[ROOT_W-1:OFS_W], 12'h000};
    endcase
    case ($urandom_range(7))
      0: item.entry = '1;
      1: item.entry = '0;
      default: item.entry = {$urandom, $urandom};
    endcase
    return item;
  endfunction

  // Offers one item on the in side, idling first as the phase asks. The
  // decision to wait is made at the falling edge, where in_full has settled,
  // and the transfer then happens at the next rising edge.
  task automatic send_item(input walk_stim_t item);
    walk_result_t want;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push            <= 1'b1;
    in_command         <= item.cmd;
    in_virtual_address <= item.va;
    in_table_root      <= item.root;
    in_entry_data      <= item.entry;
    do begin
      @(negedge clk);
      if (in_full) full_stalls++;
    end while (in_full);
    @(posedge clk);
    want = predict_walk(item);
    if (item.pinned) want = '{item.kind, item.addr, item.lvl};
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Random traffic. Most of it is complete walks, a start followed by four
  // entries. The rest is walks cut short, which a later start abandons, and
  // bursts of responses that are strays unless they follow a cut-short walk.
  task automatic random_walks(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned steps;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        steps = (pick < 72) ? 4 : $urandom_range(3);
        send_item(random_item(CMD_START));
        for (k = 0; k < steps; k++) send_item(random_item(CMD_RESPONSE));
        sent += steps + 1;
      end else begin
        steps = $urandom_range(2, 1);
        for (k = 0; k < steps; k++) send_item(random_item(CMD_RESPONSE));
        sent += steps;
      end
    end
  endtask

  // Receiver. Pop is decided at each rising edge; during a hold-off the
  // receiver takes nothing at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_active) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The long hold-off counts its own cycles, so the sender keeps offering
  // items meanwhile and the block has to fill up and raise in_full.
  always begin
    @(start_hold);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Result checker. At the falling edge the out ports hold the result that
  // the next rising edge will transfer, so it is compared here against the
  // oldest prediction.
  always @(negedge clk) begin : result_check
    walk_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (out_result_kind == KIND_DONE) walks_done++;
      if (out_result_kind == KIND_STRAY) strays_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: kind %0d addr %h level %0d",
                   out_result_kind, out_result_address, out_walk_level);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind || out_result_address !== want.addr ||
            out_walk_level !== want.lvl) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch on result %0d: expected kind %0d addr %h level %0d,",
                     results_checked, want.kind, want.addr, want.lvl);
            $display("  got kind %0d addr %h level %0d",
                     out_result_kind, out_result_address, out_walk_level);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Main sequence: reset, the directed table with no idling, then random
  // walks in four phases of sender and receiver idling.
  initial begin : main_sequence
    int unsigned row;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < N_DIRECTED; row++) send_item(directed_rows[row]);

    // No idling at all, with a long receiver hold-off at the start so that
    // the queue fills and the sender sees in_full.
    -> start_hold;
    random_walks(200);

    sender_idle_pct = 53;
    random_walks(160);

    sender_idle_pct = 0;
    recv_stall_pct  = 53;
    random_walks(160);

    sender_idle_pct = 16;
    recv_stall_pct  = 16;
    random_walks(160);

    // Let the remaining results drain with the receiver always ready.
    in_push        <= 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items; checked %0d results, %0d finished translations, %0d strays.",
             items_sent, results_checked, walks_done, strays_seen);
    $display("Sender saw in_full for %0d cycles; %0d mismatches in %0d cycles.",
             full_stalls, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ptw_pkg.sv
rtl/ptw_front.sv
rtl/ptw_queue.sv
rtl/ptw_back.sv
rtl/four_level_page_table_walker_unit.sv
verif/tb.sv
